FILE: rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types, register indexes and sequencer encodings for the point
// evaluator and its shared multiplier.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int VAL_W     = 64;
	localparam int ACC_W     = 128;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT  = 2'd3;

	localparam logic [CFG_W-1:0] MAX_ITERS_RST    = 16'd1000;
	localparam logic [CFG_W-1:0] RED_WEIGHT_RST   = 16'd54722;
	localparam logic [CFG_W-1:0] GREEN_WEIGHT_RST = 16'd7534;
	localparam logic [CFG_W-1:0] BLUE_WEIGHT_RST  = 16'd3279;

	localparam logic [VAL_W-1:0] SQ_CAP = (64'd1 << 62) - 64'd1;

	typedef struct packed {
		logic signed [31:0] c_real;
		logic signed [31:0] c_imag;
	} mbe_point_t;

	typedef struct packed {
		logic [15:0] iter_count;
		logic        in_set;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} mbe_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_Y2,
		ST_CM,
		ST_CQ,
		ST_BP,
		ST_CHK,
		ST_XY,
		ST_XS,
		ST_YS,
		ST_COL_R,
		ST_COL_G,
		ST_COL_B,
		ST_EMIT
	} mbe_state_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_PART,
		M_ADD,
		M_FIN
	} mbe_mul_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
	} mbe_mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [VAL_W-1:0] p;
		logic [VAL_W-1:0]        raw;
	} mbe_mul_rsp_t;

endpackage

FILE: rtl/core/mbe_mul.sv
// ----------------------------------------------------------------------------
// Shared fixed-point multiplier
// Signed 64 x 64 product built from 32 x 32 partial products, one per cycle,
// skipping partials whose high halves are zero. Floors the result to
// FRAC_BITS fraction bits and saturates the magnitude at 2^62 - 1.
// ----------------------------------------------------------------------------
module mbe_mul #(
	parameter int FRAC_BITS = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbe_pkg::mbe_mul_req_t req,
	output mbe_pkg::mbe_mul_rsp_t rsp
);
	import mbe_pkg::*;

	mbe_mul_state_t          mst_q, mst_d;
	logic [VAL_W-1:0]        ua_q, ub_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        acc_q;
	logic [VAL_W-1:0]        part_q;
	logic [1:0]              sh_q;
	logic [1:0]              step_q;
	logic signed [VAL_W-1:0] p_q;
	logic                    done_q;

	logic [3:0]              en;
	logic [31:0]             op_a, op_b;
	logic [VAL_W-1:0]        prod;
	logic                    nxt_found;
	logic [1:0]              nxt_step;
	logic [1:0]              step_sh;
	logic [ACC_W-1:0]        part_sh;
	logic [VAL_W-1:0]        q_raw, q_sat, q_mag;
	logic                    sat, rem, inc;
	logic signed [VAL_W-1:0] p_fin;
	logic [VAL_W-1:0]        mag_a, mag_b;

	assign mag_a = req.a[VAL_W-1] ? (~req.a + 64'd1) : req.a;
	assign mag_b = req.b[VAL_W-1] ? (~req.b + 64'd1) : req.b;

	assign en      = {(|ua_q[63:32]) & (|ub_q[63:32]), |ua_q[63:32], |ub_q[63:32], 1'b1};
	assign op_a    = step_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign op_b    = step_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign prod    = op_a * op_b;
	assign step_sh = {1'b0, step_q[1]} + {1'b0, step_q[0]};

	always_comb begin
		nxt_found = 1'b0;
		nxt_step  = step_q;
		for (int i = 0; i < 4; i++) begin
			if (!nxt_found && 2'(i) > step_q && en[i]) begin
				nxt_found = 1'b1;
				nxt_step  = 2'(i);
			end
		end
	end

	always_comb begin
		case (sh_q)
			2'd0:    part_sh = {64'd0, part_q};
			2'd1:    part_sh = {32'd0, part_q, 32'd0};
			default: part_sh = {part_q, 64'd0};
		endcase
	end

	assign q_raw = acc_q[FRAC_BITS +: VAL_W];
	assign sat   = |acc_q[ACC_W-1:FRAC_BITS+62];
	assign rem   = |acc_q[FRAC_BITS-1:0];
	assign q_sat = sat ? SQ_CAP : q_raw;
	assign inc   = neg_q && rem && !sat && (q_sat != SQ_CAP);
	assign q_mag = q_sat + 64'(inc);
	assign p_fin = neg_q ? -$signed(q_mag) : $signed(q_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q  <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			mst_q  <= mst_d;
			done_q <= (mst_q == M_FIN);
		end
	end

	always_comb begin
		mst_d = mst_q;
		case (mst_q)
			M_IDLE: if (req.start) mst_d = M_PART;
			M_PART: if (!nxt_found) mst_d = M_ADD;
			M_ADD:  mst_d = M_FIN;
			M_FIN:  mst_d = M_IDLE;
			default: mst_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (mst_q)
			M_IDLE: if (req.start) begin
				ua_q   <= mag_a;
				ub_q   <= mag_b;
				neg_q  <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
				acc_q  <= '0;
				part_q <= '0;
				sh_q   <= 2'd0;
				step_q <= 2'd0;
			end
			M_PART: begin
				acc_q  <= acc_q + part_sh;
				part_q <= prod;
				sh_q   <= step_sh;
				step_q <= nxt_step;
			end
			M_ADD: acc_q <= acc_q + part_sh;
			M_FIN: p_q <= p_fin;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;
	assign rsp.raw  = acc_q[VAL_W-1:0];

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> mst_q == M_IDLE)
		else $error("multiplier started while busy");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		mst_q == M_FIN |=> done_q && mst_q == M_IDLE)
		else $error("finish not followed by done");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(mst_q) == M_FIN)
		else $error("done without finish");
`endif

endmodule

FILE: rtl/core/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time point evaluator
// Tests one complex point against the main cardioid and period-2 bulb, then
// iterates z = z^2 + c and returns the count, an in-set flag and a colour.
// ----------------------------------------------------------------------------
// Every product goes through one shared multiplier (mbe_mul), whose work grows
// with k, the number of 32 x 32 partial products with nonzero halves:
// k = 1 while both operands stay below 2^32 in raw units, which holds for
// Q4.28 throughout the iteration, and at most 4. One iteration is three
// products and one escape check. One point is worked on at a time; the result
// register lets the next point be accepted while the previous result waits
// to be taken.
module mandelbrot_escape_time #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             point_valid,
	output logic                             point_ready,
	input  mbe_pkg::mbe_point_t              point,
	output logic                             result_valid,
	input  logic                             result_ready,
	output mbe_pkg::mbe_result_t             result,
	input  logic                             cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbe_pkg::CFG_W-1:0]        cfg_data
);
	import mbe_pkg::*;

	localparam logic signed [VAL_W-1:0] FX_ONE       = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [VAL_W-1:0] FX_NEG_ONE   = -FX_ONE;
	localparam logic signed [VAL_W-1:0] FX_QUARTER   = 64'sd1 <<< (FRAC_BITS - 2);
	localparam logic signed [VAL_W-1:0] FX_SIXTEENTH = 64'sd1 <<< (FRAC_BITS - 4);
	localparam logic [VAL_W-1:0]        FX_ESC       = 64'd4 << FRAC_BITS;
	localparam logic [32:0]             CMAX_W       = (33'd1 << COUNT_WIDTH) - 33'd1;

	mbe_state_t              st_q, st_d;
	logic                    busy_q;
	logic [CFG_W-1:0]        max_iters_q, red_weight_q, green_weight_q, blue_weight_q;
	logic signed [VAL_W-1:0] x_q, y_q, xm_q, xp_q, y2_q, q_q;
	logic signed [VAL_W-1:0] xn_q, yn_q, xs_q, ys_q;
	logic                    card_ok_q, bulb_ok_q, inside_q;
	logic [COUNT_WIDTH-1:0]  n_q;
	logic [7:0]              red_q, green_q, blue_q;
	logic                    res_valid_q;
	mbe_result_t             res_q;

	mbe_mul_req_t            mul_req;
	mbe_mul_rsp_t            mul_rsp;

	logic signed [VAL_W-1:0] x_in, y_in, xp_in;
	logic                    y_box, card_in, bulb_in;
	logic [COUNT_WIDTH-1:0]  limit_w;
	logic [VAL_W-1:0]        esc_sum;
	logic                    run_on;
	logic [18:0]             wk_r, wk_g, wk_b;
	logic [7:0]              col_byte;
	logic signed [VAL_W-1:0] rhs_card;
	logic                    card_hit, bulb_hit;
	logic                    accept, emit_load;
	logic                    mul_state;

	mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign x_in    = {{32{point.c_real[31]}}, point.c_real};
	assign y_in    = {{32{point.c_imag[31]}}, point.c_imag};
	assign xp_in   = x_in + FX_ONE;
	assign y_box   = (y_in > FX_NEG_ONE) && (y_in < FX_ONE);
	assign card_in = y_box && (x_in > FX_NEG_ONE) && (x_in < FX_ONE);
	assign bulb_in = y_box && (xp_in > FX_NEG_ONE) && (xp_in < FX_ONE);

	assign limit_w  = ({17'd0, max_iters_q} > CMAX_W) ? '1 : COUNT_WIDTH'(max_iters_q);
	assign esc_sum  = xs_q + ys_q;
	assign run_on   = (esc_sum <= FX_ESC) && (n_q < limit_w);

	assign wk_r = ({3'd0, red_weight_q} << 2) + {3'd0, red_weight_q};
	assign wk_g = ({3'd0, green_weight_q} << 3) - {3'd0, green_weight_q};
	assign wk_b = ({3'd0, blue_weight_q} << 1) + {3'd0, blue_weight_q};
	assign col_byte = (|mul_rsp.raw[63:24]) ? 8'hFF : mul_rsp.raw[23:16];

	assign rhs_card = {2'b00, y2_q[VAL_W-1:2]};
	assign card_hit = mul_rsp.p <= rhs_card;
	assign bulb_hit = (mul_rsp.p + y2_q) <= FX_SIXTEENTH;

	assign point_ready = (st_q == ST_IDLE);
	assign accept      = point_valid && point_ready;
	assign emit_load   = (st_q == ST_EMIT) && (!res_valid_q || result_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iters_q    <= MAX_ITERS_RST;
			red_weight_q   <= RED_WEIGHT_RST;
			green_weight_q <= GREEN_WEIGHT_RST;
			blue_weight_q  <= BLUE_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ITERS:    max_iters_q    <= cfg_data;
				REG_RED_WEIGHT:   red_weight_q   <= cfg_data;
				REG_GREEN_WEIGHT: green_weight_q <= cfg_data;
				REG_BLUE_WEIGHT:  blue_weight_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (mul_rsp.done) busy_q <= 1'b0;
			else if (mul_req.start) busy_q <= 1'b1;
			if (emit_load) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		mul_state = st_q inside {ST_Y2, ST_CM, ST_CQ, ST_BP, ST_XY, ST_XS, ST_YS,
			ST_COL_R, ST_COL_G, ST_COL_B};
		mul_req.start = mul_state && !busy_q;
		mul_req.a     = '0;
		mul_req.b     = '0;
		st_d          = st_q;
		case (st_q)
			ST_IDLE: if (accept) begin
				st_d = (card_in || bulb_in) ? ST_Y2 : ST_CHK;
			end
			ST_Y2: begin
				mul_req.a = y_q;
				mul_req.b = y_q;
				if (mul_rsp.done) st_d = card_ok_q ? ST_CM : ST_BP;
			end
			ST_CM: begin
				mul_req.a = xm_q;
				mul_req.b = xm_q;
				if (mul_rsp.done) st_d = ST_CQ;
			end
			ST_CQ: begin
				mul_req.a = q_q;
				mul_req.b = q_q + xm_q;
				if (mul_rsp.done) begin
					if (card_hit) st_d = ST_EMIT;
					else if (bulb_ok_q) st_d = ST_BP;
					else st_d = ST_CHK;
				end
			end
			ST_BP: begin
				mul_req.a = xp_q;
				mul_req.b = xp_q;
				if (mul_rsp.done) st_d = bulb_hit ? ST_EMIT : ST_CHK;
			end
			ST_CHK: begin
				if (run_on) st_d = ST_XY;
				else if (n_q == limit_w) st_d = ST_EMIT;
				else st_d = ST_COL_R;
			end
			ST_XY: begin
				mul_req.a = xn_q;
				mul_req.b = yn_q;
				if (mul_rsp.done) st_d = ST_XS;
			end
			ST_XS: begin
				mul_req.a = xn_q;
				mul_req.b = xn_q;
				if (mul_rsp.done) st_d = ST_YS;
			end
			ST_YS: begin
				mul_req.a = yn_q;
				mul_req.b = yn_q;
				if (mul_rsp.done) st_d = ST_CHK;
			end
			ST_COL_R: begin
				mul_req.a = 64'(n_q);
				mul_req.b = 64'(wk_r);
				if (mul_rsp.done) st_d = ST_COL_G;
			end
			ST_COL_G: begin
				mul_req.a = 64'(n_q);
				mul_req.b = 64'(wk_g);
				if (mul_rsp.done) st_d = ST_COL_B;
			end
			ST_COL_B: begin
				mul_req.a = 64'(n_q);
				mul_req.b = 64'(wk_b);
				if (mul_rsp.done) st_d = ST_EMIT;
			end
			ST_EMIT: if (emit_load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Point datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (accept) begin
				x_q       <= x_in;
				y_q       <= y_in;
				xm_q      <= x_in - FX_QUARTER;
				xp_q      <= xp_in;
				card_ok_q <= card_in;
				bulb_ok_q <= bulb_in;
				xn_q      <= '0;
				yn_q      <= '0;
				xs_q      <= '0;
				ys_q      <= '0;
				n_q       <= '0;
				inside_q  <= 1'b0;
			end
			ST_Y2: if (mul_rsp.done) y2_q <= mul_rsp.p;
			ST_CM: if (mul_rsp.done) q_q <= mul_rsp.p + y2_q;
			ST_CQ: if (mul_rsp.done && card_hit) inside_q <= 1'b1;
			ST_BP: if (mul_rsp.done && bulb_hit) inside_q <= 1'b1;
			ST_CHK: if (!run_on) inside_q <= (n_q == limit_w);
			ST_XY: if (mul_rsp.done) begin
				yn_q <= {mul_rsp.p[VAL_W-2:0], 1'b0} + y_q;
				xn_q <= xs_q - ys_q + x_q;
			end
			ST_XS: if (mul_rsp.done) xs_q <= mul_rsp.p;
			ST_YS: if (mul_rsp.done) begin
				ys_q <= mul_rsp.p;
				n_q  <= n_q + COUNT_WIDTH'(1);
			end
			ST_COL_R: if (mul_rsp.done) red_q <= col_byte;
			ST_COL_G: if (mul_rsp.done) green_q <= col_byte;
			ST_COL_B: if (mul_rsp.done) blue_q <= col_byte;
			ST_EMIT: if (emit_load) begin
				res_q.iter_count <= 16'(n_q);
				res_q.in_set     <= inside_q;
				res_q.red        <= inside_q ? 8'hFF : red_q;
				res_q.green      <= inside_q ? 8'hFF : green_q;
				res_q.blue       <= inside_q ? 8'hFF : blue_q;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTH
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> busy_q)
		else $error("multiplier result without a request");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CHK |-> n_q <= limit_w)
		else $error("iteration count beyond limit");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == ST_Y2 || st_q == ST_CHK) && !busy_q)
		else $error("point accepted into a busy sequencer");
`endif

endmodule

FILE: bench/mandelbrot_escape_time_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time evaluator testbench
// Drives complex points through the request channel and checks every result
// against a table value or a bit-accurate escape-time predictor. Runs a directed
// table first, then random phases over several iteration limits and colour weights.
// Uses bursty requests, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;
	import mbe_pkg::*;

	localparam int     FRAC            = 28;
	localparam longint FX_ONE          = longint'(1) << FRAC;
	localparam longint FX_QUARTER      = longint'(1) << (FRAC - 2);
	localparam longint FX_SIXTEENTH    = longint'(1) << (FRAC - 4);
	localparam longint FX_ESC          = longint'(4) << FRAC;
	localparam int     HOLD_OFF_CYCLES = 3000;
	localparam int     EXP_DEPTH       = 256;

	typedef enum {MIX_NEAR, MIX_FAST} point_mix_t;

	typedef struct packed {
		mbe_point_t  pt;
		logic        known;
		mbe_result_t res;
	} point_row_t;

	localparam mbe_result_t RES_SHORTCUT = '{16'd0, 1'b1, 8'd255, 8'd255, 8'd255};
	localparam mbe_result_t RES_ONE_STEP = '{16'd1, 1'b0, 8'd4, 8'd0, 8'd0};
	localparam mbe_result_t RES_NONE     = '0;

	localparam point_row_t DIRECTED_POINTS [22] = '{
		'{'{32'sd0, 32'sd0}, 1'b1, RES_SHORTCUT},
		'{'{-32'sd268435456, 32'sd0}, 1'b1, RES_SHORTCUT},
		'{'{-32'sd134217728, 32'sd0}, 1'b1, RES_SHORTCUT},
		'{'{32'sd67108864, 32'sd0}, 1'b1, RES_SHORTCUT},
		'{'{32'h8000_0000, 32'h8000_0000}, 1'b1, RES_ONE_STEP},
		'{'{32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1, RES_ONE_STEP},
		'{'{32'h8000_0000, 32'sd0}, 1'b1, RES_ONE_STEP},
		'{'{32'sd0, 32'h8000_0000}, 1'b1, RES_ONE_STEP},
		'{'{32'h7FFF_FFFF, 32'sd0}, 1'b1, RES_ONE_STEP},
		'{'{32'sd0, 32'h7FFF_FFFF}, 1'b1, RES_ONE_STEP},
		'{'{32'sd536870912, 32'sd0}, 1'b0, RES_NONE},
		'{'{-32'sd536870912, 32'sd0}, 1'b0, RES_NONE},
		'{'{32'sd0, 32'sd268435456}, 1'b0, RES_NONE},
		'{'{-32'sd335544320, 32'sd0}, 1'b0, RES_NONE},
		'{'{32'sd69793219, 32'sd0}, 1'b0, RES_NONE},
		'{'{-32'sd201326592, 32'sd13421773}, 1'b0, RES_NONE},
		'{'{-32'sd471071369, 32'sd0}, 1'b0, RES_NONE},
		'{'{32'sd80530637, 32'sd134217728}, 1'b0, RES_NONE},
		'{'{-32'sd26843546, 32'sd174483046}, 1'b0, RES_NONE},
		'{'{32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, RES_NONE},
		'{'{32'hFFFF_FFFF, 32'h0000_0001}, 1'b0, RES_NONE},
		'{'{32'sd67108865, 32'sd0}, 1'b0, RES_NONE}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 point_valid;
	logic                 point_ready;
	mbe_point_t           point;
	logic                 result_valid;
	logic                 result_ready;
	mbe_result_t          result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic [CFG_W-1:0] cur_max_iters;
	logic [CFG_W-1:0] cur_red_weight;
	logic [CFG_W-1:0] cur_green_weight;
	logic [CFG_W-1:0] cur_blue_weight;

	mbe_result_t expected_fifo [EXP_DEPTH];
	int          sent_count;
	int          checked_count;
	mbe_result_t want_result;
	int          mismatch_count;
	int          hold_offs_asked;
	int          burst_left;
	logic        tx_steady;
	logic        rx_steady;

	mandelbrot_escape_time u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// floored product, magnitude saturated at SQ_CAP
	function automatic longint fixed_mul(input longint a, input longint b);
		logic         neg;
		logic         sat;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [63:0]  q;
		logic [127:0] prod;
		neg  = (a < 0) != (b < 0);
		ua   = a < 0 ? 64'(-a) : 64'(a);
		ub   = b < 0 ? 64'(-b) : 64'(b);
		prod = {64'd0, ua} * {64'd0, ub};
		sat  = (prod >> FRAC) > {64'd0, SQ_CAP};
		q    = sat ? SQ_CAP : prod[FRAC +: 64];
		if (neg && prod[FRAC-1:0] != '0 && !sat && q < SQ_CAP)
			q = q + 64'd1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [7:0] colour_byte(input int unsigned n, input logic [15:0] w,
			input int unsigned k);
		longint v;
		v = (longint'(n) * longint'(w) * longint'(k)) >>> 16;
		return v > 255 ? 8'd255 : v[7:0];
	endfunction

	function automatic mbe_result_t predict_escape(input mbe_point_t p);
		longint      x, y, xm, y2, q, lhs, xp, xn, yn, xs, ys;
		logic        hit;
		int unsigned n;
		mbe_result_t r;
		x   = longint'(signed'(p.c_real));
		y   = longint'(signed'(p.c_imag));
		hit = 1'b0;
		n   = 0;
		if (magnitude(x) < FX_ONE && magnitude(y) < FX_ONE) begin
			xm  = x - FX_QUARTER;
			y2  = fixed_mul(y, y);
			q   = fixed_mul(xm, xm) + y2;
			lhs = fixed_mul(q, q + xm);
			hit = lhs <= (y2 >>> 2);
		end
		if (!hit && magnitude(x + FX_ONE) < FX_ONE && magnitude(y) < FX_ONE) begin
			xp  = x + FX_ONE;
			hit = fixed_mul(xp, xp) + fixed_mul(y, y) <= FX_SIXTEENTH;
		end
		if (!hit) begin
			xn = 0;
			yn = 0;
			xs = 0;
			ys = 0;
			while (xs + ys <= FX_ESC && n < cur_max_iters) begin
				yn = 2 * fixed_mul(xn, yn) + y;
				xn = (xs - ys) + x;
				xs = fixed_mul(xn, xn);
				ys = fixed_mul(yn, yn);
				n++;
			end
		end
		r.iter_count = n[15:0];
		r.in_set     = hit || n == cur_max_iters;
		if (r.in_set) begin
			r.red   = 8'd255;
			r.green = 8'd255;
			r.blue  = 8'd255;
		end else begin
			r.red   = colour_byte(n, cur_red_weight, 5);
			r.green = colour_byte(n, cur_green_weight, 7);
			r.blue  = colour_byte(n, cur_blue_weight, 3);
		end
		return r;
	endfunction

	function automatic mbe_point_t gen_point(input point_mix_t mix);
		mbe_point_t  p;
		int unsigned pick;
		int          re;
		int          im;
		pick = $urandom_range(0, 99);
		if (mix == MIX_FAST && pick < 50) begin
			re = int'($urandom_range(32'h2100_0000, 32'h7FFF_FFFF));
			if ($urandom_range(0, 1))
				re = -re;
			im = int'($urandom);
		end else if (mix == MIX_FAST || (pick >= 70 && pick < 85)) begin
			re = int'($urandom_range(0, 67108864)) - 33554432;
			im = int'($urandom_range(0, 67108864)) - 33554432;
			if ($urandom_range(0, 1))
				re = re - 268435456;
		end else if (pick < 55) begin
			re = int'($urandom_range(0, 805306368)) - 603979776;
			im = int'($urandom_range(0, 805306368)) - 402653184;
		end else if (pick < 70) begin
			re = int'($urandom);
			im = int'($urandom);
		end else if (pick < 93) begin
			re = -201326592 + int'($urandom_range(0, 16777216)) - 8388608;
			im = int'($urandom_range(0, 33554432)) - 16777216;
		end else begin
			re = 67108864 + int'($urandom_range(0, 13421773));
			im = int'($urandom_range(0, 8388608)) - 4194304;
		end
		p.c_real = re;
		p.c_imag = im;
		return p;
	endfunction

	task automatic send_point(input mbe_point_t p, input logic known, input mbe_result_t res);
		point       <= p;
		point_valid <= 1'b1;
		do
			@(posedge clk);
		while (!point_ready);
		expected_fifo[sent_count % EXP_DEPTH] = known ? res : predict_escape(p);
		sent_count++;
	endtask

	task automatic pace_sender();
		int gap;
		gap = 0;
		if (!tx_steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap        = $urandom_range(1, 20);
				burst_left = $urandom_range(1, 8);
			end
		end
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_points(input int count, input point_mix_t mix);
		for (int i = 0; i < count; i++) begin
			send_point(gen_point(mix), 1'b0, RES_NONE);
			pace_sender();
		end
		point_valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (checked_count != sent_count)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MAX_ITERS:    cur_max_iters    = val;
			REG_RED_WEIGHT:   cur_red_weight   = val;
			REG_GREEN_WEIGHT: cur_green_weight = val;
			REG_BLUE_WEIGHT:  cur_blue_weight  = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] max_iters, input logic [CFG_W-1:0] rw,
			input logic [CFG_W-1:0] gw, input logic [CFG_W-1:0] bw);
		drain_results();
		write_reg(REG_MAX_ITERS, max_iters);
		write_reg(REG_RED_WEIGHT, rw);
		write_reg(REG_GREEN_WEIGHT, gw);
		write_reg(REG_BLUE_WEIGHT, bw);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (checked_count == sent_count) begin
				$display("%0t ns: result expected none, got %h", $time, result);
				mismatch_count++;
			end else begin
				want_result = expected_fifo[checked_count % EXP_DEPTH];
				checked_count++;
				check_field("iter_count", want_result.iter_count, result.iter_count);
				check_field("in_set", want_result.in_set, result.in_set);
				check_field("red", want_result.red, result.red);
				check_field("green", want_result.green, result.green);
				check_field("blue", want_result.blue, result.blue);
			end
		end
	end

	initial begin : result_sink
		int hold_offs_done;
		hold_offs_done = 0;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_offs_done != hold_offs_asked) begin
				hold_offs_done++;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (rx_steady) begin
				result_ready <= 1'b1;
				@(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n           <= 1'b0;
		point_valid      <= 1'b0;
		point            <= '0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		tx_steady        = 1'b0;
		rx_steady        = 1'b0;
		hold_offs_asked  = 0;
		mismatch_count   = 0;
		sent_count       = 0;
		checked_count    = 0;
		burst_left       = 1;
		cur_max_iters    = MAX_ITERS_RST;
		cur_red_weight   = RED_WEIGHT_RST;
		cur_green_weight = GREEN_WEIGHT_RST;
		cur_blue_weight  = BLUE_WEIGHT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_POINTS[i]) begin
			send_point(DIRECTED_POINTS[i].pt, DIRECTED_POINTS[i].known, DIRECTED_POINTS[i].res);
			pace_sender();
		end
		point_valid <= 1'b0;

		tx_steady = 1'b1;
		rx_steady = 1'b1;
		apply_settings(16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
		run_points(6, MIX_NEAR);

		// hold the result side off while requests keep coming
		rx_steady = 1'b0;
		apply_settings(16'd1, 16'd0, 16'd0, 16'd0);
		hold_offs_asked++;
		run_points(40, MIX_NEAR);

		tx_steady = 1'b0;
		rx_steady = 1'b1;
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_points(20, MIX_FAST);

		rx_steady = 1'b0;
		apply_settings(16'd32, 16'($urandom), 16'($urandom), 16'($urandom));
		run_points(40, MIX_NEAR);

		tx_steady = 1'b1;
		apply_settings(16'd200, 16'($urandom), 16'($urandom), 16'($urandom));
		run_points(40, MIX_NEAR);

		tx_steady = 1'b0;
		apply_settings(16'd1000, 16'hFFFF, 16'd0, 16'($urandom));
		run_points(40, MIX_NEAR);

		drain_results();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && checked_count == sent_count)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
